/* rtl/assert_macros.svh */
// Assertion macros shared by the translator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked while out of reset.
`define DPT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// Checked on every edge, reset included.
`define DPT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define DPT_ASSERT(lbl, clk, rstn, prop)
`define DPT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

/* rtl/dpt_pkg.sv */
// Shared types and constants of the demand-paging translator.
package dpt_pkg;

  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PAGE_W      = 8;
  localparam int unsigned OFFS_W      = ADDR_W - PAGE_W;
  localparam int unsigned PAGE_COUNT  = 2 ** PAGE_W;
  localparam int unsigned PAGE_BYTES  = 2 ** OFFS_W;
  localparam int unsigned FRAME_COUNT = 256;
  localparam int unsigned BACK_DEPTH  = 2 ** ADDR_W;
  // copy counter runs 0..PAGE_BYTES, one extra step for the trailing write
  localparam int unsigned CNT_W       = OFFS_W + 1;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XLATE = 1'b1
  } dpt_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_COPY,
    ST_FETCH,
    ST_READ
  } dpt_state_e;

  typedef struct packed {
    logic load_wr;   // write request byte into backing store
    logic start;     // latch translate request, read page table
    logic hit_rd;    // page present: read frame memory
    logic map;       // page absent: allocate frame, start copy
    logic copy;      // one step of the page copy
    logic fetch_rd;  // read frame memory after copy
    logic result;    // load output register
  } dpt_cmd_t;

  typedef struct packed {
    logic page_hit;
    logic copy_last;
    logic out_free;
  } dpt_sts_t;

endpackage

/* rtl/dpt_ram.sv */
// Generic simple dual-port RAM with registered read.
module dpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/dpt_ctrl.sv */
// Sequencing state machine of the demand-paging translator.
`include "assert_macros.svh"
module dpt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                opcode_i,
  input  dpt_pkg::dpt_sts_t   sts_i,
  output logic                in_ready_o,
  output dpt_pkg::dpt_cmd_t   cmd_o
);

  dpt_pkg::dpt_state_e state_q, state_d;
  logic                take;
  logic                is_xlate;

  assign is_xlate = (dpt_pkg::dpt_op_e'(opcode_i) == dpt_pkg::OP_XLATE);
  assign take     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dpt_pkg::ST_IDLE: begin
        if (take && is_xlate) state_d = dpt_pkg::ST_CHECK;
      end
      dpt_pkg::ST_CHECK: begin
        state_d = sts_i.page_hit ? dpt_pkg::ST_READ : dpt_pkg::ST_COPY;
      end
      dpt_pkg::ST_COPY: begin
        if (sts_i.copy_last) state_d = dpt_pkg::ST_FETCH;
      end
      dpt_pkg::ST_FETCH: begin
        state_d = dpt_pkg::ST_READ;
      end
      dpt_pkg::ST_READ: begin
        if (sts_i.out_free) begin
          state_d = (take && is_xlate) ? dpt_pkg::ST_CHECK : dpt_pkg::ST_IDLE;
        end
      end
      default: state_d = dpt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      dpt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      dpt_pkg::ST_CHECK: begin
        cmd_o.hit_rd = sts_i.page_hit;
        cmd_o.map    = !sts_i.page_hit;
      end
      dpt_pkg::ST_COPY: begin
        cmd_o.copy = 1'b1;
      end
      dpt_pkg::ST_FETCH: begin
        cmd_o.fetch_rd = 1'b1;
      end
      dpt_pkg::ST_READ: begin
        cmd_o.result = sts_i.out_free;
        in_ready_o   = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
    cmd_o.load_wr = take && !is_xlate;
    cmd_o.start   = take && is_xlate;
  end

  `DPT_ASSERT_ALWAYS(a_busy_not_ready, clk_i,
    ((state_q != dpt_pkg::ST_IDLE) && (state_q != dpt_pkg::ST_READ)) |-> !in_ready_o)

endmodule

/* rtl/dpt_datapath.sv */
// Page table, frame allocation, page copy and output register.
`include "assert_macros.svh"
module dpt_datapath #(
  parameter int unsigned FRAME_COUNT = dpt_pkg::FRAME_COUNT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dpt_pkg::dpt_cmd_t          cmd_i,
  output dpt_pkg::dpt_sts_t          sts_o,
  input  logic [dpt_pkg::ADDR_W-1:0] address_i,
  input  logic [dpt_pkg::BYTE_W-1:0] load_byte_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [dpt_pkg::ADDR_W-1:0] logical_address_o,
  output logic [dpt_pkg::ADDR_W-1:0] physical_address_o,
  output logic signed [dpt_pkg::BYTE_W-1:0] read_value_o,
  output logic                       page_fault_o
);

  localparam int unsigned FRAME_W    = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int unsigned FADDR_W    = FRAME_W + dpt_pkg::OFFS_W;
  localparam int unsigned FMEM_DEPTH = FRAME_COUNT * dpt_pkg::PAGE_BYTES;
  localparam logic [FRAME_W-1:0] FRAME_LAST = FRAME_W'(FRAME_COUNT - 1);
  localparam int unsigned CW = dpt_pkg::CNT_W;

  logic [dpt_pkg::ADDR_W-1:0]   addr_q;
  logic [dpt_pkg::PAGE_W-1:0]   page_q;
  logic [dpt_pkg::OFFS_W-1:0]   offset_q;
  logic [dpt_pkg::PAGE_COUNT-1:0] valid_q, valid_d;
  logic [FRAME_W-1:0]           nff_q, nff_d;
  logic [FRAME_W-1:0]           frame_q;
  logic                         fault_q;
  logic [CW-1:0]                cnt_q, cnt_m1;
  logic [FRAME_W-1:0]           pt_rdata;
  logic [dpt_pkg::BYTE_W-1:0]   bk_rdata;
  logic [dpt_pkg::BYTE_W-1:0]   fr_rdata;
  logic                         fr_we;
  logic [FADDR_W-1:0]           fr_waddr, fr_raddr, phys_full;
  logic [FRAME_W-1:0]           rd_frame;
  logic                         out_valid_q;

  assign page_q   = addr_q[dpt_pkg::ADDR_W-1 -: dpt_pkg::PAGE_W];
  assign offset_q = addr_q[dpt_pkg::OFFS_W-1:0];
  assign cnt_m1   = cnt_q - CW'(1);

  assign sts_o.page_hit  = valid_q[page_q];
  assign sts_o.copy_last = (cnt_q == CW'(dpt_pkg::PAGE_BYTES));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      addr_q <= address_i;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.map) valid_d[page_q] = 1'b1;
  end

  assign nff_d = (nff_q == FRAME_LAST) ? '0 : nff_q + FRAME_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      nff_q   <= '0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      if (cmd_i.map) begin
        nff_q <= nff_d;
        cnt_q <= '0;
      end else if (cmd_i.copy) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hit_rd) begin
      frame_q <= pt_rdata;
      fault_q <= 1'b0;
    end else if (cmd_i.map) begin
      frame_q <= nff_q;
      fault_q <= 1'b1;
    end
  end

  dpt_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (dpt_pkg::PAGE_COUNT)
  ) u_page_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.map),
    .waddr_i (page_q),
    .wdata_i (nff_q),
    .re_i    (cmd_i.start),
    .raddr_i (address_i[dpt_pkg::ADDR_W-1 -: dpt_pkg::PAGE_W]),
    .rdata_o (pt_rdata)
  );

  dpt_ram #(
    .WIDTH (dpt_pkg::BYTE_W),
    .DEPTH (dpt_pkg::BACK_DEPTH)
  ) u_backing (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_wr),
    .waddr_i (address_i),
    .wdata_i (load_byte_i),
    .re_i    (cmd_i.copy),
    .raddr_i ({page_q, cnt_q[dpt_pkg::OFFS_W-1:0]}),
    .rdata_o (bk_rdata)
  );

  // each copy write lands in the cycle after its backing read
  assign fr_we    = cmd_i.copy && (cnt_q != '0);
  assign fr_waddr = {frame_q, cnt_m1[dpt_pkg::OFFS_W-1:0]};
  assign rd_frame = cmd_i.hit_rd ? pt_rdata : frame_q;
  assign fr_raddr = {rd_frame, offset_q};

  dpt_ram #(
    .WIDTH (dpt_pkg::BYTE_W),
    .DEPTH (FMEM_DEPTH)
  ) u_frames (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (bk_rdata),
    .re_i    (cmd_i.hit_rd || cmd_i.fetch_rd),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  assign phys_full = {frame_q, offset_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result) begin
      logical_address_o  <= addr_q;
      physical_address_o <= dpt_pkg::ADDR_W'(phys_full);
      read_value_o       <= signed'(fr_rdata);
      page_fault_o       <= fault_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `DPT_ASSERT(a_result_slot_free, clk_i, rst_ni, cmd_i.result |-> sts_o.out_free)
  `DPT_ASSERT(a_map_only_on_miss, clk_i, rst_ni, cmd_i.map |-> !sts_o.page_hit)
  `DPT_ASSERT(a_map_sets_valid, clk_i, rst_ni, cmd_i.map |=> valid_q[page_q])
  `DPT_ASSERT(a_map_moves_free, clk_i, rst_ni, cmd_i.map |=> (nff_q != $past(nff_q)))

endmodule

/* rtl/demand_paging_translator.sv */
// Top level of the demand-paging translator.
// Usage: one request channel (opcode_i, address_i, load_byte_i) and one
// result channel (logical_address_o, physical_address_o, read_value_o,
// page_fault_o), both valid/ready.
// A load request (opcode 0) writes load_byte_i into the backing store at
// address_i and gives no result.
// A translate request (opcode 1) looks up page address_i[15:8] in the page
// table. On a hit the page table is read, then the frame memory.
// A miss allocates the next frame in order and copies the 256-byte page
// from the backing store, one byte per cycle over the single backing read
// port, and no new request is taken until the faulting one is done.
// Results pass from the registered frame memory read into an output register
// and stay there until taken; a new request can be taken while one waits.
// When the receiver stalls with a result held, the next translate stops in
// its final cycle until the register frees; loads keep flowing meanwhile
// only while no translate is in progress.
// Reset clears the page-valid bits and the free-frame pointer, so every
// page faults on first touch; no memory sweep is needed.
module demand_paging_translator #(
  parameter int unsigned FRAME_COUNT = dpt_pkg::FRAME_COUNT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              opcode_i,
  input  logic [dpt_pkg::ADDR_W-1:0]        address_i,
  input  logic [dpt_pkg::BYTE_W-1:0]        load_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [dpt_pkg::ADDR_W-1:0]        logical_address_o,
  output logic [dpt_pkg::ADDR_W-1:0]        physical_address_o,
  output logic signed [dpt_pkg::BYTE_W-1:0] read_value_o,
  output logic                              page_fault_o
);

  dpt_pkg::dpt_cmd_t cmd;
  dpt_pkg::dpt_sts_t sts;

  dpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  dpt_datapath #(
    .FRAME_COUNT (FRAME_COUNT)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .address_i          (address_i),
    .load_byte_i        (load_byte_i),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .logical_address_o  (logical_address_o),
    .physical_address_o (physical_address_o),
    .read_value_o       (read_value_o),
    .page_fault_o       (page_fault_o)
  );

endmodule
